// ----- rtl/csv_line_field_splitter_top_defines.svh -----
// ----------------------------------------------------------------------------
// CSV line field splitter assertion macros
// Shared property wrappers for the splitter's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef CSV_LINE_FIELD_SPLITTER_TOP_DEFINES_SVH
`define CSV_LINE_FIELD_SPLITTER_TOP_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define CSVS_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("csv splitter check failed");

// Check that cons holds in the cycle after ante.
`define CSVS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("csv splitter check failed");

`endif

// ----- rtl/csvs_pkg.sv -----
// ----------------------------------------------------------------------------
// CSV line field splitter package
// Character codes, limits and result kinds shared by the splitter.
// ----------------------------------------------------------------------------
package csvs_pkg;

  // Field limits
  localparam int unsigned MAX_FIELDS     = 8;
  localparam int unsigned FIELD_CAPACITY = 256;

  // Payload widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned FIELD_W = 3;
  localparam int unsigned POS_W   = 8;
  localparam int unsigned TOTAL_W = 4;
  localparam int unsigned KIND_W  = 3;

  // Character codes
  localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
  localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;

  // Result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_NONE = 3'd0,
    KIND_DATA = 3'd1,
    KIND_SEP  = 3'd2,
    KIND_DONE = 3'd3,
    KIND_ERR  = 3'd4
  } kind_t;

endpackage

// ----- rtl/csv_line_field_splitter_top.sv -----
// ----------------------------------------------------------------------------
// CSV line field splitter
// Splits a byte stream of one text line into comma-separated, optionally
// quoted fields, one result per input item.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis: one line byte per item in tdata[7:0]; an item with
//   tlast high carries no byte and ends the line, resetting the parser.
//   Output stream m_axis: exactly one result per input item. tuser holds the
//   result kind (nothing, data byte, separator, line done, error); tdata
//   holds the byte, field number, position in field and field count.
//   The result of an accepted item is registered and presented on m_axis
//   from the next cycle on.
//   Throughput is one item per cycle while the receiver keeps up; the parse
//   state (mode, field index, field length) updates with each accepted
//   item; the one result register is refilled in the same cycle it is drained.
//   When the receiver stalls, the result register holds its item and
//   s_axis_tready drops until that item is taken.
//   Reset (rst, synchronous) empties the result register and returns the
//   parser to the unquoted start of a line.
// ----------------------------------------------------------------------------
`include "csv_line_field_splitter_top_defines.svh"

module csv_line_field_splitter_top
  import csvs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_byte
  input  logic        s_axis_tlast,   // line_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] data_byte, [10:8] field_number,
                                      // [18:11] char_position,
                                      // [22:19] field_total, [23] zero
  output logic [2:0]  m_axis_tuser    // [2:0] result_kind
);

  typedef enum logic [2:0] {
    MODE_UNQ  = 3'd0,
    MODE_INQ  = 3'd1,
    MODE_PEND = 3'd2,
    MODE_DONE = 3'd3,
    MODE_ERR  = 3'd4
  } mode_t;

  // Parser state
  mode_t              mode, mode_next;
  logic [FIELD_W-1:0] cur_field, cur_field_next;
  logic [POS_W-1:0]   field_len, field_len_next;

  // Result register
  kind_t              res_kind;
  logic [BYTE_W-1:0]  res_byte;
  logic [FIELD_W-1:0] res_field;
  logic [POS_W-1:0]   res_pos;
  logic [TOTAL_W-1:0] res_total;

  // Next result
  kind_t              kind_next;
  logic [BYTE_W-1:0]  byte_next;
  logic [FIELD_W-1:0] field_next;
  logic [POS_W-1:0]   pos_next;
  logic [TOTAL_W-1:0] total_next;

  logic              in_accept;
  logic [BYTE_W-1:0] ch;
  logic              is_quote;
  logic              unq_path;
  logic              app_path;
  logic [BYTE_W-1:0] app_byte;
  logic              len_full;
  logic              fields_full;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign ch            = s_axis_tdata;
  assign is_quote      = (ch == CH_QUOTE);
  assign len_full      = (32'(field_len) + 32'd1 >= FIELD_CAPACITY);
  assign fields_full   = (32'(cur_field) + 32'd1 >= MAX_FIELDS);

  // Work out the next parser state and the result of the current item
  always_comb begin
    mode_next      = mode;
    cur_field_next = cur_field;
    field_len_next = field_len;
    kind_next      = KIND_NONE;
    byte_next      = '0;
    field_next     = '0;
    pos_next       = '0;
    total_next     = '0;
    unq_path       = 1'b0;
    app_path       = 1'b0;
    app_byte       = ch;

    if (s_axis_tlast) begin
      // End of line: report and restart
      case (mode)
        MODE_UNQ, MODE_PEND: begin
          kind_next  = KIND_DONE;
          field_next = cur_field;
          total_next = {1'b0, cur_field} + 4'd1;
        end
        MODE_INQ: begin
          kind_next  = KIND_ERR;
          field_next = cur_field;
        end
        default: begin
          kind_next = KIND_NONE;
        end
      endcase
      mode_next      = MODE_UNQ;
      cur_field_next = '0;
      field_len_next = '0;
    end else begin
      case (mode)
        MODE_UNQ: begin
          unq_path = 1'b1;
        end
        MODE_INQ: begin
          if (is_quote) begin
            mode_next = MODE_PEND;
          end else begin
            app_path = 1'b1;
          end
        end
        MODE_PEND: begin
          if (is_quote) begin
            mode_next = MODE_INQ;
            app_path  = 1'b1;
            app_byte  = CH_QUOTE;
          end else begin
            mode_next = MODE_UNQ;
            unq_path  = 1'b1;
          end
        end
        default: begin
          kind_next = KIND_NONE;
        end
      endcase

      // Byte outside quotes
      if (unq_path) begin
        if (is_quote) begin
          if (field_len != '0) begin
            kind_next  = KIND_ERR;
            field_next = cur_field;
            mode_next  = MODE_ERR;
          end else begin
            mode_next = MODE_INQ;
          end
        end else if (ch == CH_COMMA) begin
          if (fields_full) begin
            kind_next  = KIND_ERR;
            field_next = cur_field;
            mode_next  = MODE_ERR;
          end else begin
            kind_next      = KIND_SEP;
            field_next     = cur_field;
            cur_field_next = cur_field + 3'd1;
            field_len_next = '0;
            mode_next      = MODE_UNQ;
          end
        end else if (ch == CH_LF || ch == CH_CR) begin
          kind_next  = KIND_DONE;
          field_next = cur_field;
          total_next = {1'b0, cur_field} + 4'd1;
          mode_next  = MODE_DONE;
        end else begin
          app_path = 1'b1;
        end
      end

      // Append a byte to the current field
      if (app_path) begin
        if (len_full) begin
          kind_next  = KIND_ERR;
          field_next = cur_field;
          mode_next  = MODE_ERR;
        end else begin
          kind_next      = KIND_DATA;
          byte_next      = app_byte;
          field_next     = cur_field;
          pos_next       = field_len;
          field_len_next = field_len + 8'd1;
        end
      end
    end
  end

  // Advance parser state and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_UNQ;
      cur_field     <= '0;
      field_len     <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (in_accept) begin
        mode          <= mode_next;
        cur_field     <= cur_field_next;
        field_len     <= field_len_next;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Load result payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      res_kind  <= kind_next;
      res_byte  <= byte_next;
      res_field <= field_next;
      res_pos   <= pos_next;
      res_total <= total_next;
    end
  end

  assign m_axis_tuser = res_kind;
  assign m_axis_tdata = {1'b0, res_total, res_pos, res_field, res_byte};

  // Checks
  `CSVS_ASSERT_NEXT(a_result_follows, clk, rst, in_accept, m_axis_tvalid)
  `CSVS_ASSERT_NEXT(a_quiet_after_end, clk, rst,
    in_accept && !s_axis_tlast && (mode == MODE_DONE || mode == MODE_ERR),
    m_axis_tuser == KIND_NONE)
  `CSVS_ASSERT_SAME(a_pos_in_range, clk, rst,
    m_axis_tvalid && m_axis_tuser == KIND_DATA,
    32'(m_axis_tdata[18:11]) + 32'd1 < FIELD_CAPACITY)
  `CSVS_ASSERT_SAME(a_total_matches, clk, rst,
    m_axis_tvalid && m_axis_tuser == KIND_DONE,
    m_axis_tdata[22:19] == {1'b0, m_axis_tdata[10:8]} + 4'd1)

endmodule

// ----- dv/csv_line_field_splitter_top_tb.sv -----
// ----------------------------------------------------------------------------
// CSV line field splitter testbench
// Feeds directed and random text lines, byte by byte, into the splitter with
// random idle gaps on both streams. A behavioral copy of the field parser
// predicts one result per accepted item, and each result taken from the
// output stream is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module csv_line_field_splitter_top_tb;
  import csvs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 500000;
  localparam int LINE_ITEMS  = 740;
  localparam int LONG_HOLD   = 300;

  // Parser modes of the behavioral model
  typedef enum logic [2:0] {
    MODE_UNQ,
    MODE_INQ,
    MODE_PEND,
    MODE_DONE,
    MODE_ERR
  } split_mode_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic [2:0]  fld;
    logic [7:0]  pos;
    logic [3:0]  total;
  } split_result_t;

  typedef struct {
    logic [7:0] ch;
    logic       last;
    bit         drain_first;
  } line_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;

  line_item_t    line_bytes_q[$];
  split_result_t split_results_due[$];
  line_item_t    next_item;
  split_result_t want;
  split_result_t got;

  split_mode_t line_mode = MODE_UNQ;
  int unsigned cur_field = 0;
  int unsigned field_len = 0;

  bit drain_next = 1'b0;
  int items_sent = 0;
  int items_total = 0;
  int results_seen = 0;
  int error_count = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int hold_cycles = 0;
  bit long_hold_done = 1'b0;
  int cycle_count = 0;

  csv_line_field_splitter_top DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Field splitting prediction
  // ---------------------------------------------------------------------------
  function automatic split_result_t result_of(kind_t k, logic [7:0] d, logic [2:0] f,
                                              logic [7:0] p, logic [3:0] t);
    split_result_t r;
    r.kind  = k;
    r.data  = d;
    r.fld   = f;
    r.pos   = p;
    r.total = t;
    return r;
  endfunction

  function automatic split_result_t split_error();
    line_mode = MODE_ERR;
    return result_of(KIND_ERR, 8'd0, cur_field[2:0], 8'd0, 4'd0);
  endfunction

  function automatic split_result_t split_append(logic [7:0] b);
    split_result_t r;
    if (field_len + 1 >= FIELD_CAPACITY) return split_error();
    r = result_of(KIND_DATA, b, cur_field[2:0], field_len[7:0], 4'd0);
    field_len++;
    return r;
  endfunction

  function automatic split_result_t split_unquoted(logic [7:0] b);
    split_result_t r;
    if (b == CH_QUOTE) begin
      // a quote may only open a field
      if (field_len != 0) return split_error();
      line_mode = MODE_INQ;
      r = result_of(KIND_NONE, 8'd0, 3'd0, 8'd0, 4'd0);
    end else if (b == CH_COMMA) begin
      if (cur_field + 1 >= MAX_FIELDS) return split_error();
      r = result_of(KIND_SEP, 8'd0, cur_field[2:0], 8'd0, 4'd0);
      cur_field++;
      field_len = 0;
      line_mode = MODE_UNQ;
    end else if (b == CH_LF || b == CH_CR) begin
      r = result_of(KIND_DONE, 8'd0, cur_field[2:0], 8'd0, 4'(cur_field + 1));
      line_mode = MODE_DONE;
    end else begin
      line_mode = MODE_UNQ;
      r = split_append(b);
    end
    return r;
  endfunction

  function automatic split_result_t split_step(logic [7:0] b, logic last);
    split_result_t r;
    if (last) begin
      // end of line: report and return to the start of a line
      if (line_mode == MODE_UNQ || line_mode == MODE_PEND)
        r = result_of(KIND_DONE, 8'd0, cur_field[2:0], 8'd0, 4'(cur_field + 1));
      else if (line_mode == MODE_INQ)
        r = result_of(KIND_ERR, 8'd0, cur_field[2:0], 8'd0, 4'd0);
      else
        r = result_of(KIND_NONE, 8'd0, 3'd0, 8'd0, 4'd0);
      line_mode = MODE_UNQ;
      cur_field = 0;
      field_len = 0;
      return r;
    end
    case (line_mode)
      MODE_UNQ: r = split_unquoted(b);
      MODE_INQ: begin
        if (b == CH_QUOTE) begin
          line_mode = MODE_PEND;
          r = result_of(KIND_NONE, 8'd0, 3'd0, 8'd0, 4'd0);
        end else begin
          r = split_append(b);
        end
      end
      MODE_PEND: begin
        // doubled quote stays inside quotes, anything else closes them
        if (b == CH_QUOTE) begin
          line_mode = MODE_INQ;
          r = split_append(CH_QUOTE);
        end else begin
          line_mode = MODE_UNQ;
          r = split_unquoted(b);
        end
      end
      default: r = result_of(KIND_NONE, 8'd0, 3'd0, 8'd0, 4'd0);
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    if ($urandom_range(0, 9) < 7) return 8'($urandom_range(8'h61, 8'h7A));
    do
      b = 8'($urandom_range(0, 255));
    while (b == CH_QUOTE || b == CH_COMMA || b == CH_LF || b == CH_CR);
    return b;
  endfunction

  task automatic push_char(logic [7:0] b);
    line_item_t it;
    it.ch = b;
    it.last = 1'b0;
    it.drain_first = drain_next;
    drain_next = 1'b0;
    line_bytes_q.push_back(it);
  endtask

  task automatic push_line_end();
    line_item_t it;
    it.ch = 8'($urandom_range(0, 255));
    it.last = 1'b1;
    it.drain_first = drain_next;
    drain_next = 1'b0;
    line_bytes_q.push_back(it);
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i]);
  endtask

  // Build one line; long_len > 0 forces the first field to that length
  task automatic gen_line(int long_len);
    int sel;
    int nf;
    int flen;
    int tail;
    bit quoted;
    bit broken;
    logic [7:0] b;
    sel = $urandom_range(0, 99);
    // noise line: arbitrary bytes
    if (sel < 10 && long_len == 0) begin
      flen = $urandom_range(0, 12);
      for (int i = 0; i < flen; i++) push_char(8'($urandom_range(0, 255)));
      push_line_end();
      return;
    end
    nf = ($urandom_range(0, 11) == 0) ? $urandom_range(9, 10) : $urandom_range(1, 8);
    broken = (long_len == 0) && ($urandom_range(0, 9) == 0);
    for (int f = 0; f < nf; f++) begin
      if (f > 0) push_char(CH_COMMA);
      quoted = ($urandom_range(0, 2) == 0);
      flen = (f == 0 && long_len > 0) ? long_len : $urandom_range(0, 6);
      if (quoted) push_char(CH_QUOTE);
      for (int i = 0; i < flen; i++) begin
        if (quoted) begin
          b = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : plain_byte();
          push_char(b);
          if (b == CH_QUOTE) push_char(CH_QUOTE);
        end else begin
          b = plain_byte();
          // stray quote inside an unquoted field
          if (broken && $urandom_range(0, 7) == 0) b = CH_QUOTE;
          push_char(b);
        end
      end
      // a broken line may leave its last quote open
      if (quoted && !(broken && f == nf - 1)) push_char(CH_QUOTE);
    end
    // finish early with a line break and trailing junk
    if ($urandom_range(0, 5) == 0) begin
      push_char($urandom_range(0, 1) ? CH_LF : CH_CR);
      tail = $urandom_range(0, 3);
      for (int i = 0; i < tail; i++) push_char(8'($urandom_range(0, 255)));
    end
    push_line_end();
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offer queued line items with random gaps
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      send_idle = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        split_results_due.push_back(split_step(s_axis_tdata, s_axis_tlast));
        items_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_idle > 0) begin
          send_idle--;
          s_axis_tvalid <= 1'b0;
        end else if (line_bytes_q.size() != 0 &&
                     !(line_bytes_q[0].drain_first && split_results_due.size() != 0)) begin
          next_item = line_bytes_q.pop_front();
          s_axis_tdata  <= next_item.ch;
          s_axis_tlast  <= next_item.last;
          s_axis_tvalid <= 1'b1;
          send_idle = (((items_sent / 90) % 4) == 2) ? 0 : pick_idle();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: take results with random stalls and check them
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      recv_idle = 0;
      hold_cycles = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_of(kind_t'(m_axis_tuser), m_axis_tdata[7:0], m_axis_tdata[10:8],
                        m_axis_tdata[18:11], m_axis_tdata[22:19]);
        if (split_results_due.size() == 0) begin
          $display("%0t: unexpected result kind %0d byte %h field %0d pos %0d total %0d",
                   $time, got.kind, got.data, got.fld, got.pos, got.total);
          error_count++;
        end else begin
          want = split_results_due.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected kind %0d byte %h field %0d pos %0d total %0d",
                     $time, want.kind, want.data, want.fld, want.pos, want.total);
            $display("%0t:          actual   kind %0d byte %h field %0d pos %0d total %0d",
                     $time, got.kind, got.data, got.fld, got.pos, got.total);
            error_count++;
          end
        end
        results_seen++;
      end
      // one long stall so the input side backs up
      if (!long_hold_done && results_seen >= 200) begin
        long_hold_done = 1'b1;
        hold_cycles = LONG_HOLD;
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        m_axis_tready <= 1'b0;
      end else if (recv_idle > 0) begin
        recv_idle--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        recv_idle = (((results_seen / 70) % 4) == 1) ? 0 : pick_idle();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: build stimulus, release reset, wait for the last result
  // ---------------------------------------------------------------------------
  initial begin
    // empty line
    push_line_end();
    // plain, quoted with doubled quote, zero byte and all-ones byte
    push_text("a,\"b\"\"c\"");
    push_char(8'h00);
    push_char(8'hFF);
    push_line_end();
    // quote in the middle of a field
    push_text("a\"");
    push_line_end();
    // quote still open at the end marker
    push_text("\"q");
    push_line_end();
    // carriage return ends the line, rest ignored
    push_text("x\r\ny");
    push_line_end();
    // line break inside quotes is data, pending quote closed by the end marker
    push_text("\"\r\"");
    push_line_end();
    // one separator too many
    push_text(",,,,,,,,");
    push_line_end();

    // longest allowed field, then one byte over
    drain_next = 1'b1;
    gen_line(FIELD_CAPACITY - 1);
    gen_line(FIELD_CAPACITY);
    while (line_bytes_q.size() < LINE_ITEMS) begin
      if ($urandom_range(0, 24) == 0) drain_next = 1'b1;
      gen_line(0);
    end
    items_total = line_bytes_q.size();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // every item yields exactly one result
    while (results_seen < items_total) @(posedge clk);
    repeat (8) @(posedge clk);

    if (error_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // Timeout
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/csvs_pkg.sv
rtl/csv_line_field_splitter_top.sv
dv/csv_line_field_splitter_top_tb.sv
